/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define CHK_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent in a cycle implies consequent in the next
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/msort_pkg.sv */
// ---------------------------------------------------------------------------
// msort_pkg
// Types and constants shared by the sorter cell row and its top level.
// ---------------------------------------------------------------------------
package msort_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	// top level control sequence
	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} msort_state_t;

	// control broadcast to every cell
	typedef struct packed {
		logic  ins;   // insert x into the sorted row
		logic  shl;   // shift the row one place toward cell 0
		data_t x;     // value being inserted
	} cell_ctl_t;

endpackage

/* hdl/msort_if.sv */
// ---------------------------------------------------------------------------
// msort_if
// Valid/ready channels for input items and sorted result items.
// ---------------------------------------------------------------------------
interface msort_in_if;
	logic                  valid;
	logic                  ready;
	msort_pkg::data_t      value;
	logic                  last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

interface msort_out_if;
	logic                  valid;
	logic                  ready;
	msort_pkg::data_t      value_res;
	logic                  last_res;
	logic                  overflow;

	modport source (output valid, output value_res, output last_res, output overflow,
		input ready);
	modport sink   (input valid, input value_res, input last_res, input overflow,
		output ready);
endinterface

/* hdl/merge_sorter.sv */
// First result: offered in the cycle after the item marked last is accepted.
// Throughput: one input item per cycle while loading, one result per cycle
// while draining and the sink is ready; no new items are taken until the batch has drained.
// These rates are set by the cell row, which does one insert or one shift a cycle.
// Reset clears every cell's occupancy, the item count and the overflow flag.
// ---------------------------------------------------------------------------
// merge_sorter
// Batch sorter: a row of compare-and-shift cells keeps the stored items in
// ascending signed order as they arrive, then shifts them out one per cycle while the sink is ready.
// ---------------------------------------------------------------------------
module merge_sorter #(
	parameter int MAX_ITEMS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	msort_in_if.sink      din,
	msort_out_if.source   dout
);

	localparam int CW = $clog2(MAX_ITEMS + 1);

	msort_pkg::msort_state_t state_q, state_nxt;
	logic [CW-1:0]           count_q;
	logic                    ovf_q;

	logic                    in_acc, out_acc, full;
	msort_pkg::cell_ctl_t    ctl;

	logic                    gt_w    [MAX_ITEMS];
	logic                    valid_w [MAX_ITEMS];
	msort_pkg::data_t        val_w   [MAX_ITEMS];

	assign full    = (count_q == CW'(MAX_ITEMS));
	assign in_acc  = din.valid && din.ready;
	assign out_acc = dout.valid && dout.ready;

	// broadcast control for the cell row
	assign ctl.ins = in_acc && !full;
	assign ctl.shl = out_acc;
	assign ctl.x   = din.value;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			msort_pkg::ST_LOAD: begin
				if (in_acc && din.last) state_nxt = msort_pkg::ST_DRAIN;
			end
			msort_pkg::ST_DRAIN: begin
				if (out_acc && dout.last_res) state_nxt = msort_pkg::ST_LOAD;
			end
			default: state_nxt = msort_pkg::ST_LOAD;
		endcase
	end

	// channel outputs
	always_comb begin
		din.ready      = 1'b0;
		dout.valid     = 1'b0;
		dout.value_res = val_w[0];
		dout.last_res  = (count_q == CW'(1));
		dout.overflow  = ovf_q;
		case (state_q)
			msort_pkg::ST_LOAD:  din.ready  = 1'b1;
			msort_pkg::ST_DRAIN: dout.valid = 1'b1;
			default: begin
				din.ready  = 1'b0;
				dout.valid = 1'b0;
			end
		endcase
	end

	// state, item count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msort_pkg::ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_acc) begin
				if (full) ovf_q <= 1'b1;
				else      count_q <= count_q + CW'(1);
			end else if (out_acc) begin
				count_q <= count_q - CW'(1);
				if (dout.last_res) ovf_q <= 1'b0;
			end
		end
	end

	// row of sorting cells, cell 0 holds the smallest item
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic             l_gt, l_valid, r_valid;
		msort_pkg::data_t l_val, r_val;

		if (i == 0) begin : g_first
			assign l_gt    = 1'b0;
			assign l_valid = 1'b1;
			assign l_val   = din.value;
		end else begin : g_mid
			assign l_gt    = gt_w[i-1];
			assign l_valid = valid_w[i-1];
			assign l_val   = val_w[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_end
			assign r_valid = 1'b0;
			assign r_val   = '0;
		end else begin : g_inner
			assign r_valid = valid_w[i+1];
			assign r_val   = val_w[i+1];
		end

		msort_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_gt     (l_gt),
			.left_valid  (l_valid),
			.left_val    (l_val),
			.right_valid (r_valid),
			.right_val   (r_val),
			.gt          (gt_w[i]),
			.valid       (valid_w[i]),
			.val         (val_w[i])
		);
	end

endmodule

/* hdl/msort_cell.sv */
// ---------------------------------------------------------------------------
// msort_cell
// One slot of the sorted row: holds a value, makes room for an insert by
// taking its left neighbor, and takes its right neighbor when the row drains.
// ---------------------------------------------------------------------------
module msort_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  msort_pkg::cell_ctl_t  ctl,
	input  logic                  left_gt,
	input  logic                  left_valid,
	input  msort_pkg::data_t      left_val,
	input  logic                  right_valid,
	input  msort_pkg::data_t      right_val,
	output logic                  gt,
	output logic                  valid,
	output msort_pkg::data_t      val
);

	logic             valid_q;
	msort_pkg::data_t val_q;

	// empty slot counts as larger than anything; equal keeps older item first
	assign gt = !valid_q || (ctl.x < val_q);

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shl) begin
			valid_q <= right_valid;
		end else if (ctl.ins && gt) begin
			valid_q <= left_gt ? left_valid : 1'b1;
		end
	end

	// slot value
	always_ff @(posedge clk) begin
		if (ctl.shl) begin
			val_q <= right_val;
		end else if (ctl.ins && gt) begin
			val_q <= left_gt ? left_val : ctl.x;
		end
	end

	assign valid = valid_q;
	assign val   = val_q;

endmodule

/* hdl/msort_checker.sv */
// ---------------------------------------------------------------------------
// msort_checker
// Port-level checks of the sorter's load/drain sequencing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module msort_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic [31:0] out_value
);

	// loading and draining never overlap
	`CHK_ALWAYS(a_no_overlap, !(in_ready && out_valid), "input ready while draining")

	// closing item starts the drain in the next cycle
	`CHK_NEXT(a_drain_start, in_valid && in_ready && in_last, out_valid,
		"no result after closing item")

	// final result returns the block to loading
	`CHK_NEXT(a_drain_end, out_valid && out_ready && out_last, in_ready && !out_valid,
		"block not back to loading after final result")

	// a stalled result holds its value
	`CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value),
		"stalled result changed")

endmodule

bind merge_sorter msort_checker u_msort_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.in_last   (din.last),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_last  (dout.last_res),
	.out_value (dout.value_res)
);
